@@ rtl/fm_oscillator_bank_mixer_defines.svh @@
// Assertion macros shared by the FM oscillator bank RTL.
`ifndef FM_OSCILLATOR_BANK_MIXER_DEFINES_SVH
`define FM_OSCILLATOR_BANK_MIXER_DEFINES_SVH

// Check a consequence in the same cycle; needs clk and rst_n in scope.
`define FMOB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmob: same-cycle check failed");

// Check a consequence in the next cycle; needs clk and rst_n in scope.
`define FMOB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmob: next-cycle check failed");

`endif

@@ rtl/fmob_pkg.sv @@
// Package for the FM oscillator bank: sizes, register codes, types and the sine lookup.
package fmob_pkg;

    // Bank and table sizes
    localparam int NUM_OSC      = 8;
    localparam int SINE_ENTRIES = 1024;
    localparam int PHASE_BITS   = 32;

    localparam int OSC_W       = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
    localparam int CNT_W       = $clog2(NUM_OSC + 1);
    localparam int IDX_W       = $clog2(SINE_ENTRIES);
    localparam int QUARTER     = SINE_ENTRIES / 4;
    localparam int QUARTER_LEN = QUARTER + 1;

    // Mix arithmetic: sum width and reciprocal for the divide by NUM_OSC
    localparam int SUM_W    = 17 + OSC_W;
    localparam int RECIP_SH = SUM_W + OSC_W + 1;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int MUL_W    = SUM_W + RECIP_W;
    localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + NUM_OSC - 1) / NUM_OSC;

    localparam int PROD_W   = 33;

    // Configuration port
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    typedef enum logic [2:0] {
        REG_BASE_STEP      = 3'd0,
        REG_DEPTH_STEP     = 3'd1,
        REG_LFO_STEP_A     = 3'd2,
        REG_LFO_STEP_B     = 3'd3,
        REG_LFO_STEP_C     = 3'd4,
        REG_LFO_CHOICE_MAP = 3'd5
    } reg_idx_t;

    localparam logic [1:0] LFO_SEL_A = 2'd0;
    localparam logic [1:0] LFO_SEL_B = 2'd1;

    typedef struct packed {
        logic [31:0]        base_step;
        logic signed [16:0] depth_step;
        logic [23:0]        lfo_step_a;
        logic [23:0]        lfo_step_b;
        logic [23:0]        lfo_step_c;
        logic [15:0]        lfo_choice_map;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SCALE,
        ST_FINISH
    } state_t;

    // Quarter-wave sine magnitudes, built at elaboration
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef logic [14:0] quarter_t [QUARTER_LEN];

    function automatic logic [14:0] sine_mag(int unsigned j);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q15;
        r   = 64'(j) << (32 - IDX_W);
        x   = (r * 64'd1686629713) >> 30;
        x2  = (x * x) >> 30;
        t   = Q30_ONE;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s   = (x * t) >> 30;
        q15 = (s + 64'd16384) >> 15;
        if (q15 > 64'd32767)
        begin
            q15 = 64'd32767;
        end
        return q15[14:0];
    endfunction

    function automatic quarter_t build_quarter();
        quarter_t tab;
        for (int k = 0; k < QUARTER_LEN; k++)
        begin
            tab[k] = sine_mag(k);
        end
        return tab;
    endfunction

    localparam quarter_t SINE_QUARTER = build_quarter();

    // Full-wave Q1.15 sine from a table index by quarter-wave symmetry
    function automatic logic signed [15:0] sine_at(logic [IDX_W-1:0] idx);
        logic [IDX_W-3:0] j;
        logic [IDX_W-2:0] k;
        logic [14:0]      mag;
        j   = idx[IDX_W-3:0];
        k   = idx[IDX_W-2] ? ((IDX_W-1)'(QUARTER) - {1'b0, j}) : {1'b0, j};
        mag = SINE_QUARTER[k];
        return idx[IDX_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

@@ rtl/fmob_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fmob_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/fmob_cfg.sv @@
// APB configuration registers of the FM oscillator bank.
module fmob_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fmob_pkg::PADDR_W-1:0]  paddr,
    input  logic [fmob_pkg::PDATA_W-1:0]  pwdata,
    output logic [fmob_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output fmob_pkg::cfg_t                cfg
);

    import fmob_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel_idx;
    logic     wr_go;

    assign pready  = 1'b1;
    assign sel_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_go   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Decode the write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_go)
        begin
            case (sel_idx)
                REG_BASE_STEP:      cfg_next.base_step      = pwdata;
                REG_DEPTH_STEP:     cfg_next.depth_step     = $signed(pwdata[16:0]);
                REG_LFO_STEP_A:     cfg_next.lfo_step_a     = pwdata[23:0];
                REG_LFO_STEP_B:     cfg_next.lfo_step_b     = pwdata[23:0];
                REG_LFO_STEP_C:     cfg_next.lfo_step_c     = pwdata[23:0];
                REG_LFO_CHOICE_MAP: cfg_next.lfo_choice_map = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_step      <= 32'd4626099;
            cfg_reg.depth_step     <= 17'sd3043;
            cfg_reg.lfo_step_a     <= 24'd152905;
            cfg_reg.lfo_step_b     <= 24'd305809;
            cfg_reg.lfo_step_c     <= 24'd611619;
            cfg_reg.lfo_choice_map <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (sel_idx)
            REG_BASE_STEP:      prdata = cfg_reg.base_step;
            REG_DEPTH_STEP:     prdata = {15'd0, cfg_reg.depth_step};
            REG_LFO_STEP_A:     prdata = {8'd0, cfg_reg.lfo_step_a};
            REG_LFO_STEP_B:     prdata = {8'd0, cfg_reg.lfo_step_b};
            REG_LFO_STEP_C:     prdata = {8'd0, cfg_reg.lfo_step_c};
            REG_LFO_CHOICE_MAP: prdata = {16'd0, cfg_reg.lfo_choice_map};
            default:            prdata = '0;
        endcase
    end

endmodule

@@ rtl/fm_oscillator_bank_mixer.sv @@
// Top level of the FM oscillator bank: phase memory pipeline, mixer and peak tracker.
//
//   channel   signals                                            direction
//   -------   ------------------------------------------------   ---------
//   input     in_valid, in_stall, restart                        sink
//   output    out_valid, out_stall, mixed_sample, peak_level     source
//   config    psel, penable, pwrite, paddr, pwdata, ...          APB slave
//
// A sample is accepted in ST_IDLE; the next transaction is taken only after the result is
// loaded into the output register. The phase memory is read for one oscillator per cycle;
// a six-stage pipeline follows it, then the ST_SCALE and ST_FINISH states scale the sum and
// update the peak.
// After reset all phases and the peak read as zero; no clearing pass is needed.
// A new transaction is taken while a finished result waits in the output register.
module fm_oscillator_bank_mixer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [15:0]            mixed_sample,
    output logic [14:0]                   peak_level,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fmob_pkg::PADDR_W-1:0]  paddr,
    input  logic [fmob_pkg::PDATA_W-1:0]  pwdata,
    output logic [fmob_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    import fmob_pkg::*;

    `include "fm_oscillator_bank_mixer_defines.svh"

    localparam int PB = PHASE_BITS;

    cfg_t cfg;

    // Control
    state_t           state_reg;
    state_t           state_next;
    logic             in_accept;
    logic             issue_go;
    logic             out_load;
    logic [CNT_W-1:0] iss_cnt_reg;
    logic [NUM_OSC-1:0] ent_valid_reg;

    // Phase memory
    logic              ram_wr_en;
    logic [2*PB-1:0]   ram_wr_data;
    logic [2*PB-1:0]   ram_rd_data;

    // Pipeline stages
    logic              s1_vld_reg;
    logic [OSC_W-1:0]  s1_osc_reg;
    logic              s2_vld_reg;
    logic [OSC_W-1:0]  s2_osc_reg;
    logic [PB-1:0]     s2_car_reg;
    logic [PB-1:0]     s2_lfo_reg;
    logic signed [15:0] s2_lsin_reg;
    logic              s3_vld_reg;
    logic [OSC_W-1:0]  s3_osc_reg;
    logic [PB-1:0]     s3_car_reg;
    logic [PB-1:0]     s3_lfo_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic              s4_vld_reg;
    logic [OSC_W-1:0]  s4_osc_reg;
    logic [PB-1:0]     s4_car_reg;
    logic [PB-1:0]     s4_lfo_reg;
    logic [PB-1:0]     s4_step_reg;
    logic              s5_vld_reg;
    logic              s5_last_reg;
    logic [IDX_W-1:0]  s5_cidx_reg;
    logic              s6_vld_reg;
    logic              s6_last_reg;
    logic signed [15:0] s6_csin_reg;

    // Mix and peak
    logic signed [SUM_W-1:0] sum_reg;
    logic [MUL_W-1:0]        scale_prod_reg;
    logic                    neg_reg;
    logic [14:0]             peak_reg;
    logic                    out_valid_reg;
    logic signed [15:0]      out_mix_reg;
    logic [14:0]             out_peak_reg;

    // Stage combinational values
    logic                    s1_live;
    logic [PB-1:0]           s1_car;
    logic [PB-1:0]           s1_lfo;
    logic signed [PROD_W-1:0] s3_offs;
    logic [31:0]             s3_step32;
    logic [PB-1:0]           s4_new_car;
    logic [PB-1:0]           s4_new_lfo;
    logic [3:0]              s4_osc_ext;
    logic [1:0]              s4_sel;
    logic [23:0]             s4_lfo_inc;
    logic [SUM_W-1:0]        abs_sum;
    logic [SUM_W-1:0]        quot;
    logic signed [15:0]      mix;
    logic [14:0]             mag;
    logic [14:0]             peak_new;

    fmob_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fmob_ram #(
        .WIDTH (2 * PB),
        .DEPTH (NUM_OSC)
    ) u_phase_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s4_osc_reg),
        .wr_data (ram_wr_data),
        .rd_en   (issue_go),
        .rd_addr (iss_cnt_reg[OSC_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign in_accept = in_valid && !in_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_accept) state_next = ST_RUN;
            ST_RUN:    if (s6_vld_reg && s6_last_reg) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_FINISH;
            ST_FINISH: if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        issue_go = (state_reg == ST_RUN) && (iss_cnt_reg < CNT_W'(NUM_OSC));
        out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_cnt_reg   <= '0;
            ent_valid_reg <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            s6_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_vld_reg <= issue_go;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;

            // Start a sample; a restart drops every phase and the peak
            if (in_accept)
            begin
                iss_cnt_reg <= '0;
                if (restart)
                begin
                    ent_valid_reg <= '0;
                    peak_reg      <= '0;
                end
            end
            else if (issue_go)
            begin
                iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
            end

            // Mark an entry as holding a live phase pair
            if (ram_wr_en)
            begin
                ent_valid_reg[s4_osc_reg] <= 1'b1;
            end

            if (out_load)
            begin
                peak_reg <= peak_new;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage 1: phase pair arrives; an entry never written reads as zero
    assign s1_live = ent_valid_reg[s1_osc_reg];
    assign s1_car  = s1_live ? ram_rd_data[2*PB-1:PB] : '0;
    assign s1_lfo  = s1_live ? ram_rd_data[PB-1:0]    : '0;

    // Stage 3: floor of the scaled LFO offset, added to the base step
    assign s3_offs   = s3_prod_reg >>> 15;
    assign s3_step32 = cfg.base_step + 32'(s3_offs);

    // Stage 4: advance both phases and pick the LFO step for this oscillator
    assign s4_osc_ext = 4'(s4_osc_reg);
    assign s4_sel     = cfg.lfo_choice_map[{s4_osc_ext[2:0], 1'b0} +: 2];

    always_comb
    begin
        case (s4_sel)
            LFO_SEL_A: s4_lfo_inc = cfg.lfo_step_a;
            LFO_SEL_B: s4_lfo_inc = cfg.lfo_step_b;
            default:   s4_lfo_inc = cfg.lfo_step_c;
        endcase
    end

    assign s4_new_car  = s4_car_reg + s4_step_reg;
    assign s4_new_lfo  = s4_lfo_reg + PB'(s4_lfo_inc);
    assign ram_wr_en   = s4_vld_reg;
    assign ram_wr_data = {s4_new_car, s4_new_lfo};

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_osc_reg  <= iss_cnt_reg[OSC_W-1:0];

        s2_osc_reg  <= s1_osc_reg;
        s2_car_reg  <= s1_car;
        s2_lfo_reg  <= s1_lfo;
        s2_lsin_reg <= sine_at(s1_lfo[PB-1 -: IDX_W]);

        s3_osc_reg  <= s2_osc_reg;
        s3_car_reg  <= s2_car_reg;
        s3_lfo_reg  <= s2_lfo_reg;
        s3_prod_reg <= PROD_W'(cfg.depth_step) * PROD_W'(s2_lsin_reg);

        s4_osc_reg  <= s3_osc_reg;
        s4_car_reg  <= s3_car_reg;
        s4_lfo_reg  <= s3_lfo_reg;
        s4_step_reg <= PB'(s3_step32);

        s5_cidx_reg <= s4_new_car[PB-1 -: IDX_W];
        s5_last_reg <= (s4_osc_reg == OSC_W'(NUM_OSC - 1));

        s6_csin_reg <= sine_at(s5_cidx_reg);
        s6_last_reg <= s5_last_reg;
    end

    // Accumulate the carrier sines and scale the sum
    assign abs_sum = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sum_reg <= '0;
        end
        else if (s6_vld_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(s6_csin_reg);
        end

        if (state_reg == ST_SCALE)
        begin
            scale_prod_reg <= MUL_W'(abs_sum) * MUL_W'(RECIP_W'(RECIP));
            neg_reg        <= sum_reg[SUM_W-1];
        end
    end

    // Truncate toward zero, take the magnitude and track the peak
    assign quot     = SUM_W'(scale_prod_reg >> RECIP_SH);
    assign mix      = neg_reg ? -16'(quot) : 16'(quot);
    assign mag      = (quot > SUM_W'(32767)) ? 15'h7fff : 15'(quot);
    assign peak_new = (mag > peak_reg) ? mag : peak_reg;

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mix_reg  <= mix;
            out_peak_reg <= peak_new;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = out_mix_reg;
    assign peak_level   = out_peak_reg;

    // Checks
    `FMOB_ASSERT_NOW(a_wr_only_run, ram_wr_en, state_reg == ST_RUN)
    `FMOB_ASSERT_NEXT(a_restart_clears, in_accept && restart, (ent_valid_reg == '0) && (peak_reg == '0))
    `FMOB_ASSERT_NEXT(a_last_to_scale, s6_vld_reg && s6_last_reg, state_reg == ST_SCALE)
    `FMOB_ASSERT_NOW(a_issue_bound, state_reg == ST_RUN, iss_cnt_reg <= CNT_W'(NUM_OSC))

endmodule
